// File: rtl/sha1md_pkg.sv
// Shared types, constants and helper functions of the SHA-1 digest block.
`default_nettype none

package sha1md_pkg;

  // Default depth of the item queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int          ROUNDS   = 80;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  LAST_IDX = 3'd4;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

  // Initial hash words, H_INIT[0] is H0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // One queued item as the back end sees it
  typedef struct packed {
    logic       has_byte;
    logic       end_msg;
    logic [7:0] data;
  } sha1md_item_t;

  // Working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1md_vars_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha1md_in_if.sv
// Input channel: one message byte item with its flags.
`default_nettype none

interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1md_out_if.sv
// Output channel: one digest word item with its position.
`default_nettype none

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1md_front.sv
// Front end: accepts input items, drops idle ones and queues the rest.
`default_nettype none

module sha1md_front
  import sha1md_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sha1md_in_if.sink    msg,
  output logic         q_valid,
  input  logic         q_ready,
  output sha1md_item_t q_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sha1md_item_t   slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           push;
  logic           pop;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign msg.ready = (fill != CW'(DEPTH));
  // an item with neither a byte nor the end flag changes nothing: drop it
  assign push      = msg.valid && msg.ready && (msg.has_byte || msg.end_of_message);
  assign q_valid   = (fill != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= next_ptr(wr_ptr);
      if (pop)  rd_ptr <= next_ptr(rd_ptr);
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{has_byte: msg.has_byte, end_msg: msg.end_of_message,
                         data: msg.data_byte};
    end
  end

endmodule

`default_nettype wire

// File: rtl/sha1md_round.sv
// One SHA-1 round and the next message schedule word.
`default_nettype none

module sha1md_round
  import sha1md_pkg::*;
(
  input  logic [6:0]   round,
  input  sha1md_vars_t vars,
  input  logic [31:0]  w0,
  input  logic [31:0]  w2,
  input  logic [31:0]  w8,
  input  logic [31:0]  w13,
  output sha1md_vars_t vars_next,
  output logic [31:0]  w_new
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    if (round < 7'd20) begin
      f = (vars.b & vars.c) | (~vars.b & vars.d);
      k = K_CH;
    end else if (round < 7'd40) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K_PA1;
    end else if (round < 7'd60) begin
      f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
      k = K_MAJ;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K_PA2;
    end
    tmp       = rotl(vars.a, 5) + f + vars.e + k + w0;
    vars_next = '{a: tmp, b: vars.a, c: rotl(vars.b, 30), d: vars.c, e: vars.d};
    w_new     = rotl(w13 ^ w8 ^ w2 ^ w0, 1);
  end

endmodule

`default_nettype wire

// File: rtl/sha1md_back.sv
// Back end: packs bytes, pads, runs the compression and emits the digest.
`default_nettype none

module sha1md_back
  import sha1md_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  sha1md_item_t  q_item,
  sha1md_out_if.source  digest
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD80, S_PADZ, S_LEN, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t            state;
  state_t            ret_state;
  logic [15:0][31:0] blk;       // word 15 is block word 0
  logic [5:0]        pos;
  logic [60:0]       cnt;
  logic [63:0]       len;
  logic [4:0][31:0]  h;
  sha1md_vars_t      v;
  sha1md_vars_t      v_next;
  logic [31:0]       w_new;
  logic [6:0]        rnd;
  logic [2:0]        widx;
  logic              dvalid;
  logic [31:0]       dword;
  logic [2:0]        didx;
  logic              dlast;

  sha1md_round u_round (
    .round     (rnd),
    .vars      (v),
    .w0        (blk[15]),
    .w2        (blk[13]),
    .w8        (blk[7]),
    .w13       (blk[2]),
    .vars_next (v_next),
    .w_new     (w_new)
  );

  assign q_ready            = (state == S_IDLE);
  assign digest.valid       = dvalid;
  assign digest.digest_word = dword;
  assign digest.word_index  = didx;
  assign digest.last_word   = dlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      pos       <= '0;
      cnt       <= '0;
      h         <= H_INIT;
      widx      <= '0;
      dvalid    <= 1'b0;
    end else begin
      // outside S_EMIT a taken word leaves the output register empty
      if (dvalid && digest.ready && (state != S_EMIT)) dvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.has_byte) begin
              blk <= 512'({blk, q_item.data});
              cnt <= cnt + 61'd1;
              pos <= pos + 6'd1;
              if (pos == 6'd63) begin
                state     <= S_ROUND;
                ret_state <= q_item.end_msg ? S_PAD80 : S_IDLE;
                v         <= '{a: h[0], b: h[1], c: h[2], d: h[3], e: h[4]};
                rnd       <= '0;
              end else if (q_item.end_msg) begin
                state <= S_PAD80;
              end
            end else if (q_item.end_msg) begin
              state <= S_PAD80;
            end
          end
        end
        S_PAD80: begin
          len <= {cnt, 3'b000};
          blk <= 512'({blk, PAD_BYTE});
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            state     <= S_ROUND;
            ret_state <= S_PADZ;
            v         <= '{a: h[0], b: h[1], c: h[2], d: h[3], e: h[4]};
            rnd       <= '0;
          end else begin
            state <= S_PADZ;
          end
        end
        S_PADZ: begin
          if (pos == 6'd56) begin
            state <= S_LEN;
          end else begin
            blk <= 512'({blk, 8'h00});
            pos <= pos + 6'd1;
            if (pos == 6'd63) begin
              state     <= S_ROUND;
              ret_state <= S_PADZ;
              v         <= '{a: h[0], b: h[1], c: h[2], d: h[3], e: h[4]};
              rnd       <= '0;
            end
          end
        end
        S_LEN: begin
          blk <= 512'({blk, len[63:56]});
          len <= {len[55:0], 8'h00};
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            state     <= S_ROUND;
            ret_state <= S_EMIT;
            v         <= '{a: h[0], b: h[1], c: h[2], d: h[3], e: h[4]};
            rnd       <= '0;
          end
        end
        S_ROUND: begin
          v   <= v_next;
          blk <= {blk[14:0], w_new};
          rnd <= rnd + 7'd1;
          if (rnd == 7'(ROUNDS - 1)) state <= S_ADD;
        end
        S_ADD: begin
          h[0]  <= h[0] + v.a;
          h[1]  <= h[1] + v.b;
          h[2]  <= h[2] + v.c;
          h[3]  <= h[3] + v.d;
          h[4]  <= h[4] + v.e;
          state <= ret_state;
        end
        S_EMIT: begin
          if (!dvalid || digest.ready) begin
            dword  <= h[widx];
            didx   <= widx;
            dlast  <= (widx == LAST_IDX);
            dvalid <= 1'b1;
            if (widx == LAST_IDX) begin
              widx  <= '0;
              h     <= H_INIT;
              cnt   <= '0;
              pos   <= '0;
              state <= S_IDLE;
            end else begin
              widx <= widx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/sha1_message_digest.sv
// Top level of the SHA-1 digest block: front queue, back sequencer, checks.
//
//   channel  dir  payload                                 accepted when
//   msg      in   data_byte, has_byte, end_of_message      valid && ready
//   digest   out  digest_word, word_index, last_word       valid && ready
//
// The back end takes one byte per cycle from the queue while it is not
// compressing; every 64th byte starts a compression (80 rounds on one
// round unit, then the final add), and no byte is taken meanwhile. The end
// of a message shifts padding bytes one per cycle into the block register
// (the marker, zeros, then the length, with one more step to turn to the
// length), then runs one or two compressions and emits five digest words.
// Reset (rst, synchronous) loads the initial hash words and empties the
// queue. The queue keeps taking items while the back end compresses; msg
// stalls only when it is full. The fifth digest word holds in the output
// register while the back end goes on with the next message; an earlier
// waiting word holds the back end until it is taken.
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sha1md_in_if.sink    msg,
  sha1md_out_if.source digest
);

  logic         q_valid;
  logic         q_ready;
  sha1md_item_t q_item;

  // accept and queue items
  sha1md_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // pack, pad, compress and emit
  sha1md_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .digest  (digest)
  );

  // the front drops idle items, so the queue never offers one
  a_queue_no_idle: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_item.has_byte || q_item.end_msg))
    else $error("idle item reached the back end");

  // digest words leave as one unbroken burst in order
  a_word_burst: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && (digest.word_index == $past(digest.word_index) + 3'd1)))
    else $error("digest word missing or out of order");

  // the last flag marks the fifth word and only that one
  a_last_marks_fifth: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> (digest.last_word == (digest.word_index == LAST_IDX)))
    else $error("last_word does not match word_index");

endmodule

`default_nettype wire

// File: sim/sha1_message_digest_tb.sv
// Self-checking testbench of the SHA-1 digest block: byte items in, digest words checked.
`default_nettype none

module sha1_message_digest_tb;

  // SHA-1 initial hash words and round constants
  localparam logic [31:0] IV_WORD [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RK_CHOOSE = 32'h5A827999;
  localparam logic [31:0] RK_PARITY1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] RK_PARITY2 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [2:0] FINAL_WORD = 3'd4;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned RUN_LIMIT = 2000000;

  // One digest word as it should leave the block
  typedef struct packed {
    logic [31:0] word;
    logic [2:0] index;
    logic last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst;

  sha1md_in_if msg_if ();
  sha1md_out_if digest_if ();

  sha1_message_digest u_dut (
    .clk(clk),
    .rst(rst),
    .msg(msg_if),
    .digest(digest_if)
  );

  // Mirror of the hashing state: running hash, current 64-byte block and the
  // byte length of the message so far (61 bits, wraps like the hardware).
  logic [31:0] hash_state [5];
  logic [7:0] block_bytes [64];
  logic [60:0] msg_bytes;

  // Digest words still owed by the block, oldest first
  digest_word_t pending_digest [$];

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far above the slowest legal run.
  initial begin
    #RUN_LIMIT;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string text);
    $display("ERROR @%0t: %s", $realtime, text);
    error_count++;
  endtask

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Fold the current 64-byte block into the running hash (80 rounds).
  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK_CHOOSE;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK_PARITY1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = RK_PARITY2;
      end
      t = rol32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void restart_hash();
    foreach (hash_state[i]) hash_state[i] = IV_WORD[i];
    msg_bytes = '0;
  endfunction

  // Advance the mirror by one accepted item; queue the five digest words
  // when the item closes a message.
  function automatic void absorb_item(input logic [7:0] data, input logic has,
                                      input logic eom);
    logic [5:0] pos;
    logic [63:0] bit_len;
    digest_word_t owed;
    if (has || eom) items_sent++;
    if (has) begin
      pos = msg_bytes[5:0];
      block_bytes[pos] = data;
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 6'd63) fold_block();
    end
    if (!eom) return;
    // Pad: marker byte, zeros, then the 64-bit bit length in the last 8 bytes.
    // A block with no room left for the length spills into a second block.
    pos = msg_bytes[5:0];
    block_bytes[pos] = PAD_MARK;
    for (int i = int'(pos) + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (pos >= 6'd56) begin
      fold_block();
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
    fold_block();
    for (int i = 0; i < 5; i++) begin
      owed = '{word: hash_state[i], index: 3'(i), last: (3'(i) == FINAL_WORD)};
      pending_digest = {pending_digest, owed};
    end
    restart_hash();
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  // Valid stays high into the next call, which lowers it only for a gap.
  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    while ($urandom_range(99) < send_gap_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk);
    end
    msg_if.valid <= 1'b1;
    msg_if.data_byte <= data;
    msg_if.has_byte <= has;
    msg_if.end_of_message <= eom;
    do @(posedge clk); while (!msg_if.ready);
    absorb_item(data, has, eom);
  endtask

  // Send a message of random bytes with a few idle items mixed in. Close it
  // either on the last byte or with a separate byte-less end item.
  task automatic send_message(input int unsigned len, input bit end_on_byte);
    bit closing;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      closing = end_on_byte && (i == len - 1);
      send_item(8'($urandom_range(255)), 1'b1, closing);
    end
    if (len == 0 || !end_on_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Drop valid and hold off until every owed digest word has come out.
  task automatic pause_until_drained();
    msg_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // Receiver side: stall at random with the current stall rate.
  always @(posedge clk) begin
    digest_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted digest word with the oldest owed one.
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && digest_if.valid && digest_if.ready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch($sformatf("digest word %h index %0d with nothing owed",
                                  digest_if.digest_word, digest_if.word_index));
      end else begin
        want = pending_digest.pop_front();
        if (digest_if.digest_word !== want.word)
          report_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                                    digest_if.digest_word, want.word, want.index));
        if (digest_if.word_index !== want.index)
          report_mismatch($sformatf("word_index %0d, want %0d",
                                    digest_if.word_index, want.index));
        if (digest_if.last_word !== want.last)
          report_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                    digest_if.last_word, want.last, want.index));
      end
    end
  end

  // Idle items around an empty message, which must give the digest of
  // nothing, both straight after reset and after a one-byte message.
  task automatic test_idle_and_empty();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  // Known string "abc", closed on its last byte.
  task automatic test_abc_message();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // Byte extremes, and a byte-less end item whose data must be ignored.
  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  // One long message on the padding edges: 56 to 63 bytes leave no room for
  // the length and spill into a second final block, 64 bytes fill a whole
  // block that compresses right before the end.
  task automatic test_padding_edge();
    send_message(56 + $urandom_range(8), 1'($urandom_range(1)));
  endtask

  // Hold the sender until the block has drained, then start a new message.
  task automatic test_pause_until_drained();
    send_message(5, 1'b1);
    pause_until_drained();
    send_message(3, 1'b0);
  endtask

  // Short random messages at one idling setting.
  task automatic test_random_messages(input int unsigned gap_pct, input int unsigned stall,
                                      input int unsigned item_goal);
    int unsigned first_item;
    int unsigned len;
    send_gap_pct = gap_pct;
    stall_pct = stall;
    first_item = items_sent;
    while (items_sent - first_item < item_goal) begin
      len = $urandom_range(14);
      send_message(len, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    restart_hash();
    foreach (block_bytes[i]) block_bytes[i] = 8'h00;
    rst <= 1'b1;
    msg_if.valid <= 1'b0;
    msg_if.data_byte <= 8'h00;
    msg_if.has_byte <= 1'b0;
    msg_if.end_of_message <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles a third of the time, receiver stalls most of the time.
    send_gap_pct = 33;
    stall_pct = 85;
    test_idle_and_empty();
    test_abc_message();
    test_byte_extremes();
    test_padding_edge();
    test_random_messages(33, 85, 8);
    test_pause_until_drained();
    // Swap the two rates, then run flat out on both sides.
    test_random_messages(85, 33, 8);
    test_random_messages(0, 0, 8);

    msg_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_digest.size() != 0) @(posedge clk);
    // Watch a while longer for stray digest words.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sha1_message_digest.f
rtl/sha1md_pkg.sv
rtl/sha1md_in_if.sv
rtl/sha1md_out_if.sv
rtl/sha1md_front.sv
rtl/sha1md_round.sv
rtl/sha1md_back.sv
rtl/sha1_message_digest.sv
sim/sha1_message_digest_tb.sv
